// ----- design/kfd_pkg.sv -----
// ----------------------------------------------------------------------------
// kfd_pkg
// Shared types for the keypad frame decoder: frame kinds, the classified byte
// passed from the front end to the back end, configuration and result records.
// ----------------------------------------------------------------------------
package kfd_pkg;

  // longest frame the position field has to cover
  localparam int MAX_FRAME_BYTES = 21;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

  // frame id bytes
  localparam logic [7:0] ID_SCRIPT = 8'hA0;
  localparam logic [7:0] ID_BEEP   = 8'hA1;
  localparam logic [7:0] ID_ARMSEL = 8'hA3;
  localparam logic [7:0] ID_STRIP  = 8'hA4;

  // mode and strip payload codes
  localparam logic [7:0] MODE_AWAY    = 8'h41;
  localparam logic [7:0] MODE_HOME    = 8'h42;
  localparam logic [7:0] MODE_DISARM  = 8'h43;
  localparam logic [7:0] MODE_DYNAMIC = 8'h44;
  localparam logic [7:0] STRIP_NORMAL = 8'h20;
  localparam logic [7:0] STRIP_RFID   = 8'h30;

  // event kinds
  localparam logic [2:0] EV_BEEP       = 3'd0;
  localparam logic [2:0] EV_SCRIPT     = 3'd1;
  localparam logic [2:0] EV_ARMSEL     = 3'd2;
  localparam logic [2:0] EV_STRIP_NORM = 3'd3;
  localparam logic [2:0] EV_STRIP_RFID = 3'd4;

  // script targets
  localparam logic [2:0] TGT_DISARM = 3'd0;
  localparam logic [2:0] TGT_AWAY   = 3'd1;
  localparam logic [2:0] TGT_HOME   = 3'd2;

  // arm-select modes
  localparam logic [2:0] ARM_NONE   = 3'd0;
  localparam logic [2:0] ARM_AWAY   = 3'd1;
  localparam logic [2:0] ARM_HOME   = 3'd2;
  localparam logic [2:0] ARM_DISARM = 3'd3;

  // configuration register indexes
  localparam logic [2:0] REG_FORCE_DIGITS = 3'd0;
  localparam logic [2:0] REG_FORCE_LEN    = 3'd1;
  localparam logic [2:0] REG_SKIP_DIGITS  = 3'd2;
  localparam logic [2:0] REG_SKIP_LEN     = 3'd3;
  localparam logic [2:0] REG_DYN_SEL      = 3'd4;
  localparam logic [2:0] REG_SCRIPT_MASK  = 3'd5;
  localparam logic [2:0] REG_STRIP        = 3'd6;
  localparam logic [2:0] REG_BUZZER       = 3'd7;

  typedef enum logic [4:0] {
    FK_IDLE   = 5'b00001,
    FK_SCRIPT = 5'b00010,
    FK_BEEP   = 5'b00100,
    FK_ARMSEL = 5'b01000,
    FK_STRIP  = 5'b10000
  } frame_kind_t;

  // one classified frame byte (id bytes are not passed on)
  typedef struct packed {
    frame_kind_t      kind;
    logic [POS_W-1:0] pos;
    logic [7:0]       code;
    logic             dig_ok;
    logic [3:0]       dig;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [11:0] force_digits;
    logic [1:0]  force_len;
    logic [11:0] skip_digits;
    logic [1:0]  skip_len;
    logic [1:0]  dyn_sel;
    logic [5:0]  script_mask;
    logic        strip_present;
    logic        buzzer_present;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [2:0]  script_target;
    logic [63:0] pin_digits;
    logic [4:0]  pin_length;
    logic        force_hit;
    logic        skip_hit;
    logic [2:0]  arm_select_mode;
  } event_t;

endpackage

// ----- design/kfd_front.sv -----
// ----------------------------------------------------------------------------
// kfd_front
// Frame tracker: opens frames on id bytes, numbers the following bytes,
// decodes digit codes and hands each frame byte to the queue.
// ----------------------------------------------------------------------------
module kfd_front
  import kfd_pkg::*;
#(
  parameter int SCRIPT_FRAME_BYTES = 21
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       q_full,
  output logic       push,
  output item_t      item
);

  localparam logic [POS_W-1:0] SCRIPT_LEN = POS_W'(SCRIPT_FRAME_BYTES);
  localparam logic [POS_W-1:0] SHORT_LEN  = POS_W'(2);

  frame_kind_t      kind_r, kind_nxt;
  logic [POS_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] cnt_inc;
  logic [POS_W-1:0] frame_len;
  logic             accept;
  logic             dig_ok;
  logic [3:0]       dig;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cnt_inc  = cnt_r + 1'b1;
  assign frame_len = (kind_r == FK_SCRIPT) ? SCRIPT_LEN : SHORT_LEN;

  always_comb begin
    dig_ok = 1'b1;
    case (in_byte)
      8'h00: dig = 4'd0;
      8'h05: dig = 4'd1;
      8'h0A: dig = 4'd2;
      8'h0F: dig = 4'd3;
      8'h11: dig = 4'd4;
      8'h16: dig = 4'd5;
      8'h1B: dig = 4'd6;
      8'h1C: dig = 4'd7;
      8'h22: dig = 4'd8;
      8'h27: dig = 4'd9;
      default: begin
        dig    = 4'd0;
        dig_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    item.kind   = kind_r;
    item.pos    = cnt_r;
    item.code   = in_byte;
    item.dig_ok = dig_ok;
    item.dig    = dig;
    item.last   = (cnt_inc == frame_len);
    kind_nxt    = kind_r;
    cnt_nxt     = cnt_r;
    push        = 1'b0;
    if (accept) begin
      case (kind_r)
        FK_IDLE: begin
          cnt_nxt = POS_W'(1);
          case (in_byte)
            ID_SCRIPT: kind_nxt = FK_SCRIPT;
            ID_BEEP:   kind_nxt = FK_BEEP;
            ID_ARMSEL: kind_nxt = FK_ARMSEL;
            ID_STRIP:  kind_nxt = FK_STRIP;
            default:   cnt_nxt  = '0;   // unknown id, dropped
          endcase
        end
        default: begin
          push = 1'b1;
          if (item.last) begin
            kind_nxt = FK_IDLE;
            cnt_nxt  = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= FK_IDLE;
      cnt_r  <= '0;
    end else begin
      kind_r <= kind_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- design/kfd_queue.sv -----
// ----------------------------------------------------------------------------
// kfd_queue
// Small first-in first-out buffer of classified bytes between the front end
// and the back end.
// ----------------------------------------------------------------------------
module kfd_queue
  import kfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output item_t rd_item,
  output logic  full,
  output logic  empty
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  item_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == (AW + 1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- design/kfd_back.sv -----
// ----------------------------------------------------------------------------
// kfd_back
// Frame executor: gathers prefix digits, mode byte and PIN digits, and on the
// closing byte of a frame builds the event, when it fires, into the output register.
// ----------------------------------------------------------------------------
module kfd_back
  import kfd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   q_empty,
  input  item_t  q_item,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_ready,
  output event_t out_event
);

  localparam logic [POS_W-1:0] POS_MODE = POS_W'(4);

  logic [11:0] pdig_r, pdig_nxt, pdig_new;
  logic [1:0]  plen_r, plen_nxt, plen_new;
  logic [7:0]  mode_r, mode_nxt;
  logic [63:0] pin_r, pin_nxt, pin_new;
  logic [4:0]  pinlen_r, pinlen_nxt, pinlen_new;
  logic        out_valid_r, out_valid_nxt;
  event_t      ev_r, ev_nxt, ev;
  logic        fire;
  logic        out_free;
  logic        is_script;
  logic        mode_ok;
  logic [2:0]  target;

  function automatic logic pfx_match(input logic [11:0] p, input logic [1:0] pl,
                                     input logic [11:0] c, input logic [1:0] cl);
    logic [11:0] m;
    begin
      case (cl)
        2'd1:    m = 12'h00F;
        2'd2:    m = 12'h0FF;
        2'd3:    m = 12'hFFF;
        default: m = 12'h000;
      endcase
      return (cl != 2'd0) && (pl == cl) && ((p & m) == (c & m));
    end
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign pop       = !q_empty && (!q_item.last || out_free);
  assign is_script = (q_item.kind == FK_SCRIPT);
  assign out_valid = out_valid_r;
  assign out_event = ev_r;

  // digit gathering for the current byte
  always_comb begin
    pdig_new   = pdig_r;
    plen_new   = plen_r;
    pin_new    = pin_r;
    pinlen_new = pinlen_r;
    if (is_script && q_item.dig_ok) begin
      if (q_item.pos != '0 && q_item.pos < POS_MODE && plen_r != 2'd3) begin
        pdig_new[{plen_r, 2'b00} +: 4] = q_item.dig;
        plen_new = plen_r + 2'd1;
      end
      if (q_item.pos > POS_MODE && !pinlen_r[4]) begin
        pin_new[{pinlen_r[3:0], 2'b00} +: 4] = q_item.dig;
        pinlen_new = pinlen_r + 5'd1;
      end
    end
  end

  // event built from the closing byte
  always_comb begin
    ev      = '0;
    fire    = 1'b0;
    mode_ok = 1'b1;
    case (mode_r)
      MODE_AWAY:    target = TGT_AWAY;
      MODE_HOME:    target = TGT_HOME;
      MODE_DISARM:  target = TGT_DISARM;
      MODE_DYNAMIC: begin
        target  = 3'd2 + {1'b0, cfg.dyn_sel};
        mode_ok = (cfg.dyn_sel != 2'd0);
      end
      default: begin
        target  = TGT_DISARM;
        mode_ok = 1'b0;
      end
    endcase
    case (q_item.kind)
      FK_BEEP: begin
        fire          = cfg.buzzer_present;
        ev.event_kind = EV_BEEP;
      end
      FK_SCRIPT: begin
        fire             = mode_ok && (pinlen_new != 5'd0) && cfg.script_mask[target];
        ev.event_kind    = EV_SCRIPT;
        ev.script_target = target;
        ev.pin_digits    = pin_new;
        ev.pin_length    = pinlen_new;
        ev.force_hit     = pfx_match(pdig_r, plen_r, cfg.force_digits, cfg.force_len);
        ev.skip_hit      = pfx_match(pdig_r, plen_r, cfg.skip_digits, cfg.skip_len);
      end
      FK_ARMSEL: begin
        fire          = cfg.strip_present;
        ev.event_kind = EV_ARMSEL;
        case (q_item.code)
          MODE_AWAY:    ev.arm_select_mode = ARM_AWAY;
          MODE_HOME:    ev.arm_select_mode = ARM_HOME;
          MODE_DISARM:  ev.arm_select_mode = ARM_DISARM;
          MODE_DYNAMIC: ev.arm_select_mode = (cfg.dyn_sel != 2'd0) ?
                                             3'd3 + {1'b0, cfg.dyn_sel} : ARM_NONE;
          default:      ev.arm_select_mode = ARM_NONE;
        endcase
      end
      FK_STRIP: begin
        fire          = cfg.strip_present &&
                        (q_item.code == STRIP_NORMAL || q_item.code == STRIP_RFID);
        ev.event_kind = (q_item.code == STRIP_RFID) ? EV_STRIP_RFID : EV_STRIP_NORM;
      end
      default: fire = 1'b0;
    endcase
  end

  always_comb begin
    pdig_nxt      = pdig_r;
    plen_nxt      = plen_r;
    mode_nxt      = mode_r;
    pin_nxt       = pin_r;
    pinlen_nxt    = pinlen_r;
    ev_nxt        = ev_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      if (q_item.last) begin
        // frame done, start the next one clean
        pdig_nxt   = '0;
        plen_nxt   = '0;
        pin_nxt    = '0;
        pinlen_nxt = '0;
        if (fire) begin
          out_valid_nxt = 1'b1;
          ev_nxt        = ev;
        end
      end else begin
        pdig_nxt   = pdig_new;
        plen_nxt   = plen_new;
        pin_nxt    = pin_new;
        pinlen_nxt = pinlen_new;
        if (is_script && q_item.pos == POS_MODE) begin
          mode_nxt = q_item.code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    ev_r   <= ev_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pdig_r      <= '0;
      plen_r      <= '0;
      pin_r       <= '0;
      pinlen_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pdig_r      <= pdig_nxt;
      plen_r      <= plen_nxt;
      pin_r       <= pin_nxt;
      pinlen_r    <= pinlen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/keypad_frame_decoder.sv -----
// Path: a closing byte passes the queue; its event is then registered onto out_tvalid.
// Throughput: one byte per cycle; the front end stalls only when the two-entry
// queue is full, which happens when a finished event waits in the output register.
// Reset: rst_n is synchronous, active low; it closes any open frame, empties the
// queue and the output register, and clears all configuration registers to zero.
// ----------------------------------------------------------------------------
// keypad_frame_decoder
// Keypad link frame decoder: assembles id-led frames from a byte stream and
// emits beep, script, arm-select and strip events.
// ----------------------------------------------------------------------------
module keypad_frame_decoder
  import kfd_pkg::*;
#(
  parameter int SCRIPT_FRAME_BYTES = 21
) (
  input  logic        clk,
  input  logic        rst_n,
  // received_byte
  input  logic [7:0]  in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // script_target, pin_digits, pin_length, force_hit, skip_hit,
  // arm_select_mode, zero fill
  output logic [79:0] out_tdata,
  // event_kind
  output logic [2:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);

  cfg_t   cfg_r, cfg_nxt;
  item_t  f_item, q_item;
  logic   f_push, q_pop, q_full, q_empty;
  event_t ev;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_FORCE_DIGITS: cfg_nxt.force_digits   = cfg_wdata;
        REG_FORCE_LEN:    cfg_nxt.force_len      = cfg_wdata[1:0];
        REG_SKIP_DIGITS:  cfg_nxt.skip_digits    = cfg_wdata;
        REG_SKIP_LEN:     cfg_nxt.skip_len       = cfg_wdata[1:0];
        REG_DYN_SEL:      cfg_nxt.dyn_sel        = cfg_wdata[1:0];
        REG_SCRIPT_MASK:  cfg_nxt.script_mask    = cfg_wdata[5:0];
        REG_STRIP:        cfg_nxt.strip_present  = cfg_wdata[0];
        REG_BUZZER:       cfg_nxt.buzzer_present = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  kfd_front #(
    .SCRIPT_FRAME_BYTES(SCRIPT_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_ready (in_tready),
    .q_full   (q_full),
    .push     (f_push),
    .item     (f_item)
  );

  kfd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_item (f_item),
    .pop     (q_pop),
    .rd_item (q_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  kfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_event (ev)
  );

  assign out_tuser = ev.event_kind;
  assign out_tdata = {3'b000, ev.arm_select_mode, ev.skip_hit, ev.force_hit,
                      ev.pin_length, ev.pin_digits, ev.script_target};

endmodule
